// File: sv/brufns_pkg.sv
// Shared types and constants for the BMP row unpad / flip / nearest scaler.
// No dependencies; used by the scaler, the checker and the testbench.
`default_nettype none

package brufns_pkg;

  // Configuration register format
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 2;

  // Register values after reset
  localparam int SOURCE_WIDTH_RST  = 320;
  localparam int SOURCE_HEIGHT_RST = 240;
  localparam int TARGET_WIDTH_RST  = 320;
  localparam int TARGET_HEIGHT_RST = 240;

  // Default sizing
  localparam int MAX_PIXELS_DEF = 524288;
  localparam int MAX_DIM_DEF    = 2048;

  // One stored pixel: R in [23:16], G in [15:8], B in [7:0]
  localparam int PIX_W  = 24;
  localparam int BYTE_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } byte_phase_t;

  typedef enum logic [2:0] {
    ST_DIV,   // step quotients being computed after reset or a register write
    ST_IDLE,  // ready for a transaction
    ST_MUL,   // row base of the source pixel
    ST_ADDR,  // store read issued
    ST_DATA   // read data in hand, waiting for the output register
  } state_t;

endpackage

`default_nettype wire

// File: sv/bmp_row_unpad_flip_nearest_scaler.sv
// Load transaction: no result. Emit transaction: store read sequencer (multiply,
// address/read, output), result registered once the output register is free, and the
// next transaction taken after that. Emit before the source is loaded skips the read.
// Reset (synchronous) and every register write clear the load and emit counters and
// hold item_stall high while the step dividers run.
// The pixel store is not cleared; a full load writes every entry read later.
`default_nettype none

module bmp_row_unpad_flip_nearest_scaler #(
  parameter int MAX_PIXELS = brufns_pkg::MAX_PIXELS_DEF,
  parameter int MAX_DIM    = brufns_pkg::MAX_DIM_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input items
  input  wire logic                               item_valid,
  output      logic                               item_stall,
  input  wire logic                               operation,
  input  wire logic [brufns_pkg::BYTE_W-1:0]      source_byte,
  // results
  output      logic                               result_valid,
  input  wire logic                               result_stall,
  output      logic [brufns_pkg::BYTE_W-1:0]      red,
  output      logic [brufns_pkg::BYTE_W-1:0]      green,
  output      logic [brufns_pkg::BYTE_W-1:0]      blue,
  output      logic                               frame_end,
  output      logic                               not_ready,
  // configuration writes
  input  wire logic                               write_enable,
  input  wire logic [brufns_pkg::CFG_INDEX_W-1:0] register_index,
  input  wire logic [brufns_pkg::CFG_W-1:0]       write_data
);

  localparam int DW    = $clog2(MAX_DIM + 1);   // dimension / coordinate width
  localparam int AW    = $clog2(MAX_PIXELS);    // store address width
  localparam int PW    = 2 * DW;                // row base product width
  localparam int SUM_W = (PW + 1 > AW + 1) ? PW + 1 : AW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers and their effective values (0 -> 1, clamp to MAX_DIM)
  // ---------------------------------------------------------------------------
  logic [brufns_pkg::CFG_W-1:0] sw_cfg, sh_cfg, dw_cfg, dh_cfg;
  logic [DW-1:0]                sw_e, sh_e, dw_e, dh_e;

  function automatic logic [DW-1:0] eff_dim(input logic [brufns_pkg::CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign sw_e = eff_dim(sw_cfg);
  assign sh_e = eff_dim(sh_cfg);
  assign dw_e = eff_dim(dw_cfg);
  assign dh_e = eff_dim(dh_cfg);

  // ---------------------------------------------------------------------------
  // Step dividers: sw/dw and sh/dh, rerun after reset and each register write.
  // Column step adds q to map_x and 2*r to its remainder, with one carry when
  // the remainder reaches 2*dw; same for rows.
  // ---------------------------------------------------------------------------
  logic          div_start;
  logic          div_x_busy, div_y_busy;
  logic [DW-1:0] div_x_quo, div_x_rem, div_y_quo, div_y_rem;

  brufns_div #(.W(DW)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sw_e),
    .divisor   (dw_e),
    .busy      (div_x_busy),
    .quotient  (div_x_quo),
    .remainder (div_x_rem)
  );

  brufns_div #(.W(DW)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sh_e),
    .divisor   (dh_e),
    .busy      (div_y_busy),
    .quotient  (div_y_quo),
    .remainder (div_y_rem)
  );

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  brufns_pkg::state_t      state, state_next;
  brufns_pkg::byte_phase_t byte_phase;
  logic [1:0]              pad_left;
  logic [DW-1:0]           load_column, load_row;
  logic [15:0]             partial_pixel;
  logic                    loaded;
  logic [DW-1:0]           out_column, out_row;
  logic [DW-1:0]           map_x, map_y;
  logic [DW:0]             map_x_remainder, map_y_remainder;

  // emit transaction in flight
  logic [DW-1:0] emit_x, emit_y;
  logic          pend_fe, pend_nr, pend_in;
  logic [PW-1:0] rd_base;

  // load row base, refreshed every cycle; a store write never comes before it has
  // caught up with a change of load_row or the registers
  logic [PW-1:0] row_base;
  logic [DW-1:0] load_cur_row;

  logic item_accept, result_take, out_free;

  assign item_accept = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;
  assign out_free    = !result_valid || !result_stall;

  // ---------------------------------------------------------------------------
  // Store and its address paths
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]             wr_sum, rd_sum;
  logic                         wr_en, rd_en;
  logic [brufns_pkg::PIX_W-1:0] wr_data, rd_data;

  assign load_cur_row = sh_e - DW'(1) - load_row;
  assign wr_sum  = SUM_W'(row_base) + SUM_W'(load_column);
  assign rd_sum  = SUM_W'(rd_base) + SUM_W'(emit_x);
  assign wr_data = {source_byte, partial_pixel[15:8], partial_pixel[7:0]};
  assign wr_en   = item_accept && !operation && (pad_left == 2'd0) &&
                   (byte_phase == brufns_pkg::PH_RED) && (wr_sum < SUM_W'(MAX_PIXELS));

  brufns_ram #(.WIDTH(brufns_pkg::PIX_W), .DEPTH(MAX_PIXELS)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_sum[AW-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_sum[AW-1:0]),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Mapping accumulator steps
  // ---------------------------------------------------------------------------
  logic [DW:0]   two_dw, two_dh;
  logic [DW+1:0] x_sum, y_sum;
  logic          x_wrap, y_wrap;
  logic [DW:0]   x_rem_next, y_rem_next;
  logic [DW-1:0] map_x_next, map_y_next;
  logic          col_last, row_last;

  assign two_dw = {dw_e, 1'b0};
  assign two_dh = {dh_e, 1'b0};
  assign x_sum  = (DW+2)'(map_x_remainder) + (DW+2)'({div_x_rem, 1'b0});
  assign y_sum  = (DW+2)'(map_y_remainder) + (DW+2)'({div_y_rem, 1'b0});
  assign x_wrap = (x_sum >= (DW+2)'(two_dw));
  assign y_wrap = (y_sum >= (DW+2)'(two_dh));
  assign x_rem_next = x_wrap ? (DW+1)'(x_sum - (DW+2)'(two_dw)) : (DW+1)'(x_sum);
  assign y_rem_next = y_wrap ? (DW+1)'(y_sum - (DW+2)'(two_dh)) : (DW+1)'(y_sum);
  assign map_x_next = map_x + div_x_quo + DW'(x_wrap);
  assign map_y_next = map_y + div_y_quo + DW'(y_wrap);
  assign col_last   = ((DW+1)'(out_column) + (DW+1)'(1)) >= (DW+1)'(dw_e);
  assign row_last   = ((DW+1)'(out_row) + (DW+1)'(1)) >= (DW+1)'(dh_e);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    if (write_enable) begin
      state_next = brufns_pkg::ST_DIV;
    end else begin
      unique case (state)
        brufns_pkg::ST_DIV: begin
          if (!div_start && !div_x_busy && !div_y_busy) state_next = brufns_pkg::ST_IDLE;
        end
        brufns_pkg::ST_IDLE: begin
          if (item_accept && operation) begin
            state_next = loaded ? brufns_pkg::ST_MUL : brufns_pkg::ST_DATA;
          end
        end
        brufns_pkg::ST_MUL:  state_next = brufns_pkg::ST_ADDR;
        brufns_pkg::ST_ADDR: state_next = brufns_pkg::ST_DATA;
        brufns_pkg::ST_DATA: begin
          if (out_free) state_next = brufns_pkg::ST_IDLE;
        end
        default: state_next = brufns_pkg::ST_DIV;
      endcase
    end
  end

  always_comb begin
    item_stall = (state != brufns_pkg::ST_IDLE);
    rd_en      = (state == brufns_pkg::ST_ADDR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brufns_pkg::ST_DIV;
    end else begin
      state <= state_next;
    end
  end

  // Load row base and emit row base products
  always_ff @(posedge clk) begin
    row_base <= PW'(load_cur_row) * PW'(sw_e);
    if (state == brufns_pkg::ST_MUL) begin
      rd_base <= PW'(emit_y) * PW'(sw_e);
    end
    if (state == brufns_pkg::ST_ADDR) begin
      pend_in <= (rd_sum < SUM_W'(MAX_PIXELS));
    end
  end

  // ---------------------------------------------------------------------------
  // Registers, load and emit bookkeeping
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_cfg          <= brufns_pkg::CFG_W'(brufns_pkg::SOURCE_WIDTH_RST);
      sh_cfg          <= brufns_pkg::CFG_W'(brufns_pkg::SOURCE_HEIGHT_RST);
      dw_cfg          <= brufns_pkg::CFG_W'(brufns_pkg::TARGET_WIDTH_RST);
      dh_cfg          <= brufns_pkg::CFG_W'(brufns_pkg::TARGET_HEIGHT_RST);
      div_start       <= 1'b1;
      byte_phase      <= brufns_pkg::PH_BLUE;
      pad_left        <= 2'd0;
      load_column     <= '0;
      load_row        <= '0;
      partial_pixel   <= '0;
      loaded          <= 1'b0;
      out_column      <= '0;
      out_row         <= '0;
      map_x           <= '0;
      map_y           <= '0;
      map_x_remainder <= '0;
      map_y_remainder <= '0;
      pend_fe         <= 1'b0;
      pend_nr         <= 1'b0;
    end else begin
      div_start <= write_enable;
      if (write_enable) begin
        unique case (register_index)
          brufns_pkg::REG_SOURCE_WIDTH:  sw_cfg <= write_data;
          brufns_pkg::REG_SOURCE_HEIGHT: sh_cfg <= write_data;
          brufns_pkg::REG_TARGET_WIDTH:  dw_cfg <= write_data;
          brufns_pkg::REG_TARGET_HEIGHT: dh_cfg <= write_data;
        endcase
      end

      if (state == brufns_pkg::ST_DIV) begin
        // full restart from the current registers
        byte_phase      <= brufns_pkg::PH_BLUE;
        pad_left        <= 2'd0;
        load_column     <= '0;
        load_row        <= '0;
        partial_pixel   <= '0;
        loaded          <= 1'b0;
        out_column      <= '0;
        out_row         <= '0;
        map_x           <= '0;
        map_y           <= '0;
        map_x_remainder <= (DW+1)'(dw_e);
        map_y_remainder <= (DW+1)'(dh_e);
      end else if (item_accept && !operation) begin
        // a byte after a complete source starts a new frame
        if (loaded) begin
          loaded          <= 1'b0;
          out_column      <= '0;
          out_row         <= '0;
          map_x           <= '0;
          map_y           <= '0;
          map_x_remainder <= (DW+1)'(dw_e);
          map_y_remainder <= (DW+1)'(dh_e);
        end
        if (pad_left != 2'd0) begin
          pad_left <= pad_left - 2'd1;
          if (pad_left == 2'd1 && load_row == '0) loaded <= 1'b1;
        end else begin
          unique case (byte_phase)
            brufns_pkg::PH_BLUE: begin
              partial_pixel <= {8'h00, source_byte};
              byte_phase    <= brufns_pkg::PH_GREEN;
            end
            brufns_pkg::PH_GREEN: begin
              partial_pixel[15:8] <= source_byte;
              byte_phase          <= brufns_pkg::PH_RED;
            end
            default: begin
              // pixel complete: store write happens this cycle
              byte_phase    <= brufns_pkg::PH_BLUE;
              partial_pixel <= '0;
              if (((DW+1)'(load_column) + (DW+1)'(1)) >= (DW+1)'(sw_e)) begin
                load_column <= '0;
                pad_left    <= sw_e[1:0];   // row stride padding of 3*sw bytes
                if (((DW+1)'(load_row) + (DW+1)'(1)) >= (DW+1)'(sh_e)) begin
                  load_row <= '0;
                  if (sw_e[1:0] == 2'd0) loaded <= 1'b1;
                end else begin
                  load_row <= load_row + DW'(1);
                end
              end else begin
                load_column <= load_column + DW'(1);
              end
            end
          endcase
        end
      end else if (item_accept && operation) begin
        pend_fe <= 1'b0;
        pend_nr <= !loaded;
        if (loaded) begin
          emit_x <= (map_x < sw_e) ? map_x : sw_e - DW'(1);
          emit_y <= (map_y < sh_e) ? map_y : sh_e - DW'(1);
          if (col_last) begin
            out_column      <= '0;
            map_x           <= '0;
            map_x_remainder <= (DW+1)'(dw_e);
            if (row_last) begin
              // last pixel of the frame: wrap to the first target pixel
              pend_fe         <= 1'b1;
              out_row         <= '0;
              map_y           <= '0;
              map_y_remainder <= (DW+1)'(dh_e);
            end else begin
              out_row         <= out_row + DW'(1);
              map_y           <= map_y_next;
              map_y_remainder <= y_rem_next;
            end
          end else begin
            out_column      <= out_column + DW'(1);
            map_x           <= map_x_next;
            map_x_remainder <= x_rem_next;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the far side stalls
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == brufns_pkg::ST_DATA && out_free) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == brufns_pkg::ST_DATA && out_free) begin
      if (pend_nr || !pend_in) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end else begin
        red   <= rd_data[23:16];
        green <= rd_data[15:8];
        blue  <= rd_data[7:0];
      end
      frame_end <= pend_fe && !pend_nr;
      not_ready <= pend_nr;
    end
  end

endmodule

`default_nettype wire

// File: sv/brufns_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module brufns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/brufns_div.sv
// Restoring divider, one quotient bit per cycle; yields the per-pixel step
// quotient and remainder of the scaler's coordinate mapping. No dependencies.
`default_nettype none

module brufns_div #(
  parameter int W = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,   // never zero
  output      logic         busy,
  output      logic [W-1:0] quotient,
  output      logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  assign shifted = {remainder, quotient[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= CW'(W);
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      count <= count - CW'(1);
      busy  <= (count != CW'(1));
      if (!diff[W+1]) begin
        remainder <= diff[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= shifted[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/brufns_chk.sv
// Port-level checker for bmp_row_unpad_flip_nearest_scaler, bound to the top level.
// Depends on brufns_pkg for field widths.
`default_nettype none

module brufns_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic [brufns_pkg::BYTE_W-1:0] red,
  input wire logic [brufns_pkg::BYTE_W-1:0] green,
  input wire logic [brufns_pkg::BYTE_W-1:0] blue,
  input wire logic                          frame_end,
  input wire logic                          not_ready,
  input wire logic                          write_enable
);

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(frame_end) && $stable(not_ready))
    else $error("result changed while stalled");

  // a not-ready result carries no pixel and no frame end
  a_not_ready_blank: assert property (@(posedge clk) disable iff (rst)
    result_valid && not_ready |-> red == '0 && green == '0 && blue == '0 && !frame_end)
    else $error("not-ready result with pixel data");

  // reset and register writes restart the block, so inputs are held off
  a_restart_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || $past(write_enable) |-> item_stall)
    else $error("input taken right after reset or register write");

endmodule

bind bmp_row_unpad_flip_nearest_scaler brufns_chk u_brufns_chk (.*);

`default_nettype wire

// File: tb/bmp_row_unpad_flip_nearest_scaler_tb.sv
// Self-checking testbench for bmp_row_unpad_flip_nearest_scaler: BMP byte loading,
// row unpad/flip into the pixel store, and nearest-neighbour emission of the scaled frame.
// Depends on brufns_pkg and the block itself; nothing else.
module bmp_row_unpad_flip_nearest_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brufns_pkg::*;

  localparam int          MAX_PIX        = MAX_PIXELS_DEF;
  localparam int          MAX_SIDE       = MAX_DIM_DEF;
  localparam logic        OP_LOAD        = 1'b0;
  localparam logic        OP_EMIT        = 1'b1;
  localparam int unsigned IDLE_PCT       = 12;
  localparam int unsigned QUIET_LO       = 1000;   // no idling on either side in this window
  localparam int unsigned QUIET_HI       = 1600;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 470;

  typedef struct packed {
    logic             op;
    logic [BYTE_W-1:0] data;
  } byte_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              frame_end;
    logic              not_ready;
  } scaled_pixel_t;

  // DUT connections; inputs all known from time zero
  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   item_valid     = 1'b0;
  logic                   item_stall;
  logic                   operation      = OP_LOAD;
  logic [BYTE_W-1:0]      source_byte    = '0;
  logic                   result_valid;
  logic                   result_stall   = 1'b0;
  logic [BYTE_W-1:0]      red;
  logic [BYTE_W-1:0]      green;
  logic [BYTE_W-1:0]      blue;
  logic                   frame_end;
  logic                   not_ready;
  logic                   write_enable   = 1'b0;
  logic [CFG_INDEX_W-1:0] register_index = '0;
  logic [CFG_W-1:0]       write_data     = '0;

  bmp_row_unpad_flip_nearest_scaler i_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .source_byte    (source_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .frame_end      (frame_end),
    .not_ready      (not_ready),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  // Stimulus bookkeeping
  byte_cmd_t       pending_cmds[$];       // filled by the sequencer, drained by the driver
  scaled_pixel_t   scaled_pixels_due[$];  // predicted pixels, oldest first
  int unsigned     unaccepted   = 0;      // queued or on the bus, not yet taken by the DUT
  int unsigned     items_queued = 0;
  int unsigned     err_count    = 0;
  int unsigned     cycle_count  = 0;
  int unsigned     quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Scaler predictor: its own copy of the registers, load counters, emit
  // accumulators and the pixel store.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  src_w, src_h, tgt_w, tgt_h;
  byte_phase_t       byte_slot;
  int unsigned       pad_left;
  int unsigned       load_col, load_row;
  logic [15:0]       partial_gb;          // G in [15:8], B in [7:0]
  logic              frame_loaded;
  int unsigned       out_col, out_row;
  int unsigned       map_x, map_y;
  int unsigned       map_x_rem, map_y_rem;
  bit   [PIX_W-1:0]  pixel_mem [MAX_PIX];

  // zero reads as 1, anything past the largest side saturates
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic int unsigned row_pad();
    return (4 - ((eff_dim(src_w) * 3) & 3)) & 3;
  endfunction

  function automatic int unsigned frame_bytes();
    return eff_dim(src_h) * (eff_dim(src_w) * 3 + row_pad());
  endfunction

  task automatic restart_emission();
    out_col   = '0;
    out_row   = '0;
    map_x     = '0;
    map_y     = '0;
    map_x_rem = eff_dim(tgt_w);
    map_y_rem = eff_dim(tgt_h);
  endtask

  task automatic restart_frame();
    byte_slot    = PH_BLUE;
    pad_left     = '0;
    load_col     = '0;
    load_row     = '0;
    partial_gb   = '0;
    frame_loaded = 1'b0;
    restart_emission();
  endtask

  task automatic apply_register(reg_index_t idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_SOURCE_WIDTH:  src_w = val;
      REG_SOURCE_HEIGHT: src_h = val;
      REG_TARGET_WIDTH:  tgt_w = val;
      default:           tgt_h = val;
    endcase
    restart_frame();
  endtask

  task automatic scaler_load_byte(logic [BYTE_W-1:0] b);
    int unsigned sw, sh, store_row, addr;
    sw = eff_dim(src_w);
    sh = eff_dim(src_h);
    // a byte after a complete frame begins the next one
    if (frame_loaded) begin
      frame_loaded = 1'b0;
      restart_emission();
    end
    if (pad_left != 0) begin
      pad_left = pad_left - 1'b1;
      if (pad_left == 0 && load_row == 0) frame_loaded = 1'b1;
      return;
    end
    case (byte_slot)
      PH_BLUE: begin
        partial_gb = {8'h00, b};
        byte_slot  = PH_GREEN;
      end
      PH_GREEN: begin
        partial_gb[15:8] = b;
        byte_slot        = PH_RED;
      end
      default: begin
        // file rows are bottom-up; the store is top-down
        store_row = sh - 1 - load_row;
        addr      = store_row * sw + load_col;
        if (addr < MAX_PIX) pixel_mem[addr] = {b, partial_gb};
        byte_slot  = PH_BLUE;
        partial_gb = '0;
        load_col   = load_col + 1'b1;
        if (load_col >= sw) begin
          load_col = '0;
          pad_left = row_pad();
          load_row = load_row + 1'b1;
          if (load_row >= sh) begin
            load_row = '0;
            if (row_pad() == 0) frame_loaded = 1'b1;
          end
        end
      end
    endcase
  endtask

  task automatic scaler_emit_pixel();
    scaled_pixel_t px;
    int unsigned   sw, sh, dw, dh, x, y, addr, acc;
    bit [PIX_W-1:0] word;
    px = '0;
    if (!frame_loaded) begin
      px.not_ready = 1'b1;
      scaled_pixels_due.push_back(px);
      return;
    end
    sw   = eff_dim(src_w);
    sh   = eff_dim(src_h);
    dw   = eff_dim(tgt_w);
    dh   = eff_dim(tgt_h);
    x    = (map_x < sw) ? map_x : sw - 1;
    y    = (map_y < sh) ? map_y : sh - 1;
    addr = y * sw + x;
    word = (addr < MAX_PIX) ? pixel_mem[addr] : '0;
    px.red   = word[23:16];
    px.green = word[15:8];
    px.blue  = word[7:0];
    // exact (2*i*s + d) / (2*d) via quotient/remainder accumulators
    if (out_col + 1 >= dw) begin
      out_col   = '0;
      map_x     = '0;
      map_x_rem = dw;
      if (out_row + 1 >= dh) begin
        px.frame_end = 1'b1;
        restart_emission();
      end else begin
        out_row   = out_row + 1'b1;
        acc       = map_y_rem + 2 * sh;
        map_y     = map_y + acc / (2 * dh);
        map_y_rem = acc % (2 * dh);
      end
    end else begin
      out_col   = out_col + 1'b1;
      acc       = map_x_rem + 2 * sw;
      map_x     = map_x + acc / (2 * dw);
      map_x_rem = acc % (2 * dw);
    end
    scaled_pixels_due.push_back(px);
  endtask

  task automatic scaler_accept(logic op, logic [BYTE_W-1:0] b);
    if (op == OP_EMIT) scaler_emit_pixel();
    else scaler_load_byte(b);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  // Random back-pressure/gaps, except in one quiet window
  function automatic bit take_break();
    if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes/emit requests; predicts on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    byte_cmd_t cmd;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        scaler_accept(operation, source_byte);
        unaccepted--;
      end
      // payload held while stalled; only advance once the bus is free
      if (!item_valid || !item_stall) begin
        if (pending_cmds.size() != 0 && !take_break()) begin
          cmd         = pending_cmds.pop_front();
          item_valid  <= 1'b1;
          operation   <= cmd.op;
          source_byte <= cmd.data;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    scaled_pixel_t exp_px;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (scaled_pixels_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual r=%0h g=%0h b=%0h fe=%0b nr=%0b",
                   $time, red, green, blue, frame_end, not_ready);
          err_count++;
        end else begin
          exp_px = scaled_pixels_due.pop_front();
          check_field("red",       exp_px.red,       red);
          check_field("green",     exp_px.green,     green);
          check_field("blue",      exp_px.blue,      blue);
          check_field("frame_end", BYTE_W'(exp_px.frame_end), BYTE_W'(frame_end));
          check_field("not_ready", BYTE_W'(exp_px.not_ready), BYTE_W'(not_ready));
        end
      end
      result_stall <= take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any accepted transaction or register write counts as progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || write_enable) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic op, logic [BYTE_W-1:0] data);
    byte_cmd_t cmd;
    cmd.op   = op;
    cmd.data = data;
    unaccepted++;
    items_queued++;
    pending_cmds.push_back(cmd);
  endtask

  task automatic push_emits(int unsigned n);
    repeat (n) push_item(OP_EMIT, '0);
  endtask

  task automatic push_loads(int unsigned n);
    repeat (n) push_item(OP_LOAD, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Everything accepted, all results back, a settle wait for trailing loads,
  // and the dividers done
  task automatic wait_idle();
    while (unaccepted != 0 || scaled_pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    wait_idle();
    @(posedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic write_dims(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                            logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh);
    write_reg(REG_SOURCE_WIDTH,  sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH,  dw);
    write_reg(REG_TARGET_HEIGHT, dh);
  endtask

  // small sizes keep frames short; zero now and then
  function automatic logic [CFG_W-1:0] rand_dim(int unsigned hi);
    if ($urandom_range(0, 15) == 0) return '0;
    return CFG_W'($urandom_range(1, hi));
  endfunction

  task automatic pick_config(bit all);
    logic [3:0] mask;
    mask = all ? 4'hF : 4'($urandom_range(1, 15));
    if (mask[0]) write_reg(REG_SOURCE_WIDTH,  rand_dim(6));
    if (mask[1]) write_reg(REG_SOURCE_HEIGHT, rand_dim(5));
    if (mask[2]) write_reg(REG_TARGET_WIDTH,  rand_dim(8));
    if (mask[3]) write_reg(REG_TARGET_HEIGHT, rand_dim(6));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    int unsigned mode;
    int unsigned frame_px;

    src_w = SOURCE_WIDTH_RST;
    src_h = SOURCE_HEIGHT_RST;
    tgt_w = TARGET_WIDTH_RST;
    tgt_h = TARGET_HEIGHT_RST;
    restart_frame();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: emits before and during a partial load are not ready
    push_emits(1);
    push_item(OP_LOAD, 8'h00);
    push_item(OP_LOAD, 8'hFF);
    push_item(OP_LOAD, 8'h0F);
    push_emits(1);

    // All registers zero -> 1x1 frame with one pad byte per row
    write_dims('0, '0, '0, '0);
    push_emits(1);
    push_item(OP_LOAD, 8'h00);   // B
    push_item(OP_LOAD, 8'hFF);   // G
    push_item(OP_LOAD, 8'h5A);   // R
    push_item(OP_LOAD, 8'hC3);   // pad, frame complete
    push_emits(2);               // frame_end on both, wraps around
    push_item(OP_LOAD, 8'h12);   // load after complete starts a new frame
    push_emits(1);
    push_item(OP_LOAD, 8'h34);
    push_item(OP_LOAD, 8'h56);
    push_emits(1);               // pixel in but pad pending
    push_item(OP_LOAD, 8'h9A);
    push_emits(1);

    // Widest target (register above the limit), 3x3 source with 3 pad bytes/row;
    // only the start of the long target row is emitted
    write_dims(12'd3, 12'd3, 12'hFFF, 12'd1);
    push_loads(frame_bytes());
    push_emits(8);

    // Single source row, upscaled height clamps to the last row
    write_dims(12'd2, 12'd1, 12'd2, 12'd5);
    push_loads(frame_bytes());
    push_emits(eff_dim(tgt_w) * eff_dim(tgt_h) + 1);

    // Tallest target (register above the limit) from a 1x1 source
    write_dims(12'd1, 12'd1, 12'd1, 12'hFFF);
    push_loads(frame_bytes());
    push_emits(6);

    // Largest source: only a partial load is affordable, so emission stays
    // not ready
    write_dims(12'hFFF, 12'hFFF, 12'd2048, 12'd2048);
    push_loads(40);
    push_emits(1);

    // Random part: mostly complete frames followed by emission, plus partial
    // loads and noise
    random_start = items_queued;
    pick_config(1'b1);
    while (items_queued < random_start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) pick_config(1'b0);
      frame_px = eff_dim(tgt_w) * eff_dim(tgt_h);
      mode     = $urandom_range(0, 9);
      if (mode < 7) begin
        if ($urandom_range(0, 4) == 0) push_emits(1);
        push_loads(frame_bytes());
        if ($urandom_range(0, 1) != 0) push_emits(frame_px + $urandom_range(0, 2));
        else push_emits($urandom_range(1, frame_px));
      end else if (mode < 9) begin
        push_loads($urandom_range(1, frame_bytes() - 1));
        push_emits($urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(4, 16))
          push_item(logic'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
      end
      wait_idle();
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
